// ===== src/assert_macros.svh =====
// Assertion macros of the skyline allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define SRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SRA_ASSERT(lbl, clk, rst_n, prop)
`define SRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/sra_pkg.sv =====
// Types and constants of the skyline rectangle allocator.
// No dependencies; used by the interfaces, controller, datapath and top level.
package sra_pkg;

    localparam int CB       = 13;   // coordinate width
    localparam int OB       = 12;   // reported coordinate width
    localparam int SB       = 2;    // status width
    localparam int CFG_IB   = 4;    // register index width

    localparam logic [SB-1:0] ST_PLACED = 2'd0;
    localparam logic [SB-1:0] ST_NOFIT  = 2'd1;
    localparam logic [SB-1:0] ST_FULL   = 2'd2;

    localparam logic [CFG_IB-1:0] REG_ATLAS_W = 4'd0;
    localparam logic [CFG_IB-1:0] REG_ATLAS_H = 4'd1;

    localparam logic [CB-1:0] ATLAS_RESET = 13'd1024;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [CB-1:0] w;
    } t_seg;

    typedef struct packed {
        logic          start;
        logic          rd_i;
        logic          chk_i;
        logic          rd_j;
        logic          step_j;
        logic          take_best;
        logic          next_i;
        logic          commit_init;
        logic          rd_k;
        logic          emit_new;
        logic          emit_old;
        logic          flush;
        logic          out_load;
        logic [SB-1:0] out_code;
    } t_cmd;

    typedef struct packed {
        logic zero_req;
        logic i_lt_cnt;
        logic x_over;
        logic j_ge_cnt;
        logic h_over;
        logic left_done;
        logic found;
        logic full;
        logic k_lt_cnt;
        logic k_is_best;
        logic inserted;
        logic out_free;
    } t_sts;

endpackage

// ===== src/sra_if.sv =====
// Channel interfaces of the skyline allocator: request, result, configuration.
// Depends on sra_pkg.
interface sra_req_if;
    logic                   valid;
    logic                   ready;
    logic [sra_pkg::CB-1:0] req_width;
    logic [sra_pkg::CB-1:0] req_height;
    modport source (output valid, output req_width, output req_height, input ready);
    modport sink   (input valid, input req_width, input req_height, output ready);
endinterface

interface sra_res_if;
    logic                   valid;
    logic                   ready;
    logic [sra_pkg::SB-1:0] status;
    logic [sra_pkg::OB-1:0] place_x;
    logic [sra_pkg::OB-1:0] place_y;
    modport source (output valid, output status, output place_x, output place_y, input ready);
    modport sink   (input valid, input status, input place_x, input place_y, output ready);
endinterface

interface sra_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [sra_pkg::CFG_IB-1:0] index;
    logic [sra_pkg::CB-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/sra_ctrl.sv =====
// Sequencer of the skyline allocator: fit scan, decision, list rebuild, result.
// Depends on sra_pkg; drives the datapath sra_dp by command struct.
module sra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  sra_pkg::t_sts   i_sts,
    output sra_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK0  = 4'd1;
    localparam logic [3:0] S_RDI   = 4'd2;
    localparam logic [3:0] S_CHKI  = 4'd3;
    localparam logic [3:0] S_RDJ   = 4'd4;
    localparam logic [3:0] S_STEPJ = 4'd5;
    localparam logic [3:0] S_DEC   = 4'd6;
    localparam logic [3:0] S_RDK   = 4'd7;
    localparam logic [3:0] S_KSEG  = 4'd8;
    localparam logic [3:0] S_FLUSH = 4'd9;
    localparam logic [3:0] S_RES   = 4'd10;

    logic [3:0]             r_state, n_state;
    logic [sra_pkg::SB-1:0] r_code, n_code;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.out_code = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CHK0;
                end
            end
            S_CHK0: begin
                if (i_sts.zero_req) begin
                    n_code  = sra_pkg::ST_NOFIT;
                    n_state = S_RES;
                end else begin
                    n_state = S_RDI;
                end
            end
            S_RDI: begin
                if (i_sts.i_lt_cnt) begin
                    o_cmd.rd_i = 1'b1;
                    n_state    = S_CHKI;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_CHKI: begin
                o_cmd.chk_i = 1'b1;
                if (i_sts.x_over) begin
                    o_cmd.next_i = 1'b1;
                    n_state      = S_RDI;
                end else begin
                    n_state = S_RDJ;
                end
            end
            S_RDJ: begin
                if (i_sts.j_ge_cnt) begin
                    o_cmd.next_i = 1'b1;
                    n_state      = S_RDI;
                end else begin
                    o_cmd.rd_j = 1'b1;
                    n_state    = S_STEPJ;
                end
            end
            S_STEPJ: begin
                if (i_sts.h_over) begin
                    o_cmd.next_i = 1'b1;
                    n_state      = S_RDI;
                end else if (i_sts.left_done) begin
                    o_cmd.take_best = 1'b1;
                    o_cmd.next_i    = 1'b1;
                    n_state         = S_RDI;
                end else begin
                    o_cmd.step_j = 1'b1;
                    n_state      = S_RDJ;
                end
            end
            S_DEC: begin
                if (!i_sts.found) begin
                    n_code  = sra_pkg::ST_NOFIT;
                    n_state = S_RES;
                end else if (i_sts.full) begin
                    n_code  = sra_pkg::ST_FULL;
                    n_state = S_RES;
                end else begin
                    o_cmd.commit_init = 1'b1;
                    n_state           = S_RDK;
                end
            end
            S_RDK: begin
                if (i_sts.k_lt_cnt) begin
                    o_cmd.rd_k = 1'b1;
                    n_state    = S_KSEG;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_KSEG: begin
                // new segment goes in ahead of the old one it starts on
                if (i_sts.k_is_best && !i_sts.inserted) begin
                    o_cmd.emit_new = 1'b1;
                end else begin
                    o_cmd.emit_old = 1'b1;
                    n_state        = S_RDK;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_code      = sra_pkg::ST_PLACED;
                n_state     = S_RES;
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= sra_pkg::ST_NOFIT;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

// ===== src/sra_dp.sv =====
// Datapath of the skyline allocator: segment memory (two banks), scan
// arithmetic, list rebuild with trim and merge, result register.
// Depends on sra_pkg and assert_macros.svh; commanded by sra_ctrl.
`include "assert_macros.svh"
module sra_dp #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sra_pkg::t_cmd              i_cmd,
    output sra_pkg::t_sts              o_sts,
    input  logic                       i_cfg_we,
    input  logic [sra_pkg::CFG_IB-1:0] i_cfg_index,
    input  logic [sra_pkg::CB-1:0]     i_cfg_data,
    input  logic [sra_pkg::CB-1:0]     i_req_width,
    input  logic [sra_pkg::CB-1:0]     i_req_height,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic [sra_pkg::SB-1:0]     o_res_status,
    output logic [sra_pkg::OB-1:0]     o_res_place_x,
    output logic [sra_pkg::OB-1:0]     o_res_place_y
);

    localparam int CB    = sra_pkg::CB;
    localparam int OB    = sra_pkg::OB;
    localparam int IW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW    = IW + 1;
    localparam int DEPTH = 2 * (1 << IW);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

    sra_pkg::t_seg mem [DEPTH];

    logic [CB-1:0]          r_atlas_w, r_atlas_h;
    logic [CB-1:0]          r_w, r_h;
    logic [CW-1:0]          r_count;
    logic                   r_bank, r_fresh;
    logic [CW-1:0]          r_i, r_j, r_k, r_best;
    logic [CB-1:0]          r_y, r_ix, r_iw;
    logic signed [CB+1:0]   r_left;
    logic                   r_found;
    logic [CB:0]            r_best_top;
    logic [CB-1:0]          r_best_w, r_bx, r_by;
    logic [IW-1:0]          r_wptr;
    sra_pkg::t_seg          r_pend, r_rd;
    logic                   r_pend_v, r_trim, r_ins, r_rd_fresh;
    logic                   r_ovalid;
    logic [sra_pkg::SB-1:0] r_ostatus;
    logic [OB-1:0]          r_ox, r_oy;

    sra_pkg::t_seg          rd, seg_e;
    logic [IW-1:0]          rd_idx;
    logic                   rd_en;
    logic [CB-1:0]          ymax;
    logic [CB:0]            top, tend, shrink;
    logic signed [CB+1:0]   left_nx, neww;
    logic                   better, covered, drop, emit_v, merge, mem_we;

    assign rd = r_rd_fresh ? sra_pkg::t_seg'{x: '0, y: '0, w: r_atlas_w} : r_rd;

    assign rd_en  = i_cmd.rd_i | i_cmd.rd_j | i_cmd.rd_k;
    assign rd_idx = i_cmd.rd_i ? r_i[IW-1:0] : (i_cmd.rd_j ? r_j[IW-1:0] : r_k[IW-1:0]);

    // fit scan arithmetic
    assign ymax    = (rd.y > r_y) ? rd.y : r_y;
    assign top     = {1'b0, ymax} + {1'b0, r_h};
    assign left_nx = r_left - $signed({2'b00, rd.w});
    assign better  = !r_found || (top < r_best_top) ||
                     ((top == r_best_top) && (r_iw < r_best_w));

    // trim of old segments under the new one
    assign tend    = {1'b0, r_bx} + {1'b0, r_w};
    assign covered = ({1'b0, rd.x} < tend);
    assign shrink  = tend - {1'b0, rd.x};
    assign neww    = $signed({2'b00, rd.w}) - $signed({1'b0, shrink});
    assign drop    = neww[CB+1] || (neww == '0);

    always_comb begin
        seg_e  = rd;
        emit_v = 1'b0;
        if (i_cmd.emit_new) begin
            seg_e  = sra_pkg::t_seg'{x: r_bx, y: CB'({1'b0, r_by} + {1'b0, r_h}), w: r_w};
            emit_v = 1'b1;
        end else if (i_cmd.emit_old) begin
            if (r_trim && covered) begin
                seg_e  = sra_pkg::t_seg'{x: tend[CB-1:0], y: rd.y, w: neww[CB-1:0]};
                emit_v = !drop;
            end else begin
                emit_v = 1'b1;
            end
        end
    end

    // equal-height neighbours coalesce in the pending register
    assign merge  = r_pend_v && (r_pend.y == seg_e.y);
    assign mem_we = (emit_v && r_pend_v && !merge) || i_cmd.flush;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[{~r_bank, r_wptr}] <= r_pend;
        end
        if (rd_en) begin
            r_rd       <= mem[{r_bank, rd_idx}];
            r_rd_fresh <= r_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_w     <= i_req_width;
            r_h     <= i_req_height;
            r_i     <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.chk_i) begin
            r_y    <= rd.y;
            r_left <= $signed({2'b00, r_w});
            r_j    <= r_i;
            r_ix   <= rd.x;
            r_iw   <= rd.w;
        end
        if (i_cmd.step_j) begin
            r_y    <= ymax;
            r_left <= left_nx;
            r_j    <= r_j + 1'b1;
        end
        if (i_cmd.take_best && better) begin
            r_found    <= 1'b1;
            r_best     <= r_i;
            r_best_top <= top;
            r_best_w   <= r_iw;
            r_bx       <= r_ix;
            r_by       <= ymax;
        end
        if (i_cmd.next_i) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.commit_init) begin
            r_k    <= '0;
            r_wptr <= '0;
            r_trim <= 1'b0;
            r_ins  <= 1'b0;
        end
        if (i_cmd.emit_new) begin
            r_ins  <= 1'b1;
            r_trim <= 1'b1;
        end
        if (i_cmd.emit_old) begin
            r_k <= r_k + 1'b1;
            if (!(r_trim && covered && drop)) begin
                r_trim <= 1'b0;
            end
        end
        if (emit_v) begin
            if (merge) begin
                r_pend.w <= r_pend.w + seg_e.w;
            end else begin
                r_pend <= seg_e;
            end
        end
        if (emit_v && r_pend_v && !merge) begin
            r_wptr <= r_wptr + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_ostatus <= i_cmd.out_code;
            r_ox      <= (i_cmd.out_code == sra_pkg::ST_PLACED) ? r_bx[OB-1:0] : '0;
            r_oy      <= (i_cmd.out_code == sra_pkg::ST_PLACED) ? r_by[OB-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w <= sra_pkg::ATLAS_RESET;
            r_atlas_h <= sra_pkg::ATLAS_RESET;
            r_count   <= CW'(1);
            r_bank    <= 1'b0;
            r_fresh   <= 1'b1;
            r_pend_v  <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == sra_pkg::REG_ATLAS_W)) begin
                r_atlas_w <= i_cfg_data;
                r_count   <= CW'(1);
                r_fresh   <= 1'b1;
            end
            if (i_cfg_we && (i_cfg_index == sra_pkg::REG_ATLAS_H)) begin
                r_atlas_h <= i_cfg_data;
            end
            if (i_cmd.commit_init) begin
                r_pend_v <= 1'b0;
            end else if (emit_v) begin
                r_pend_v <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_count <= {1'b0, r_wptr} + CW'(1);
                r_bank  <= ~r_bank;
                r_fresh <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.zero_req  = (r_w == '0) || (r_h == '0);
        o_sts.i_lt_cnt  = (r_i < r_count);
        o_sts.x_over    = (({1'b0, rd.x} + {1'b0, r_w}) > {1'b0, r_atlas_w});
        o_sts.j_ge_cnt  = (r_j >= r_count);
        o_sts.h_over    = (top > {1'b0, r_atlas_h});
        o_sts.left_done = left_nx[CB+1] || (left_nx == '0);
        o_sts.found     = r_found;
        o_sts.full      = (r_count >= MAX_CNT);
        o_sts.k_lt_cnt  = (r_k < r_count);
        o_sts.k_is_best = (r_k == r_best);
        o_sts.inserted  = r_ins;
        o_sts.out_free  = !r_ovalid || i_res_ready;
    end

    assign o_res_valid   = r_ovalid;
    assign o_res_status  = r_ostatus;
    assign o_res_place_x = r_ox;
    assign o_res_place_y = r_oy;

    `SRA_ASSERT(a_count_range, i_clk, i_rst_n, (r_count >= CW'(1)) && (r_count <= MAX_CNT))
    `SRA_ASSERT_IMP(a_flush_pending, i_clk, i_rst_n, i_cmd.flush, r_pend_v && r_ins)
    `SRA_ASSERT_NXT(a_load_shows, i_clk, i_rst_n, i_cmd.out_load, r_ovalid)
    `SRA_ASSERT_IMP(a_load_free, i_clk, i_rst_n, i_cmd.out_load, !r_ovalid || i_res_ready)

endmodule

// ===== src/skyline_rect_allocator.sv =====
// Top level of the skyline bottom-left rectangle allocator.
// Depends on sra_pkg, sra_if, sra_ctrl and sra_dp.
//
//  port    | direction | carries
//  i_req   | in        | req_width, req_height
//  o_res   | out       | status, place_x, place_y
//  i_cfg   | in        | index, data (0 atlas_width, 1 atlas_height)
//
// One request at a time. The scan tries each start segment in turn and reads each
// segment its span covers; the rebuild then walks all segments of the list. The
// worst case is set by the scan, which reads one segment at a time from the
// single-port segment memory.
// Reset is synchronous: skyline is one segment of the full atlas width.
// A finished result sits in the output register while the next request is taken.
module skyline_rect_allocator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sra_req_if.sink      i_req,
    sra_res_if.source    o_res,
    sra_cfg_if.sink      i_cfg
);

    sra_pkg::t_cmd cmd;
    sra_pkg::t_sts sts;
    logic          req_ready;

    assign i_req.ready = req_ready;
    assign i_cfg.ready = 1'b1;

    sra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sra_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_req_width   (i_req.req_width),
        .i_req_height  (i_req.req_height),
        .o_res_valid   (o_res.valid),
        .i_res_ready   (o_res.ready),
        .o_res_status  (o_res.status),
        .o_res_place_x (o_res.place_x),
        .o_res_place_y (o_res.place_y)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the skyline rectangle allocator.
// Depends on sra_pkg, sra_if and skyline_rect_allocator; directed table, then random phases.
module tb_top;

    localparam int NSEG = 64;
    localparam int WDOG_LIMIT = 200000;
    localparam logic [sra_pkg::CFG_IB-1:0] REG_UNUSED = 4'd15;

    typedef struct {
        logic [sra_pkg::SB-1:0] status;
        logic [sra_pkg::OB-1:0] place_x;
        logic [sra_pkg::OB-1:0] place_y;
    } t_place;

    typedef struct {
        bit            is_cfg;
        int            a;        // width, or register index
        int            b;        // height, or write data
        bit            typed;
        t_place        want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    sra_req_if req_ch ();
    sra_res_if res_ch ();
    sra_cfg_if cfg_ch ();

    skyline_rect_allocator #(.MAX_SEGMENTS(NSEG)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // skyline mirror
    int sky_x [NSEG];
    int sky_y [NSEG];
    int sky_w [NSEG];
    int sky_cnt;
    int atl_w;
    int atl_h;

    t_place placements [$];
    int     n_fail;
    int     n_req, n_res, n_placed, n_nofit, n_full;
    int     burst_left;
    int     idle_cycles;
    bit     long_hold;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void sky_clear();
        for (int k = 0; k < NSEG; k++) begin
            sky_x[k] = 0;
            sky_y[k] = 0;
            sky_w[k] = 0;
        end
        sky_w[0] = atl_w;
        sky_cnt  = 1;
    endfunction

    function automatic void sky_remove(int pos);
        for (int k = pos; k + 1 < sky_cnt; k++) begin
            sky_x[k] = sky_x[k+1];
            sky_y[k] = sky_y[k+1];
            sky_w[k] = sky_w[k+1];
        end
        sky_cnt--;
    endfunction

    function automatic bit span_fits(int idx, int w, int h, output int bot);
        int y, left, i;
        y = sky_y[idx];
        left = w;
        i = idx;
        bot = 0;
        if (sky_x[idx] + w > atl_w) return 1'b0;
        while (left > 0) begin
            if (i >= sky_cnt) return 1'b0;
            if (sky_y[i] > y) y = sky_y[i];
            if (y + h > atl_h) return 1'b0;
            left -= sky_w[i];
            i++;
        end
        bot = y;
        return 1'b1;
    endfunction

    function automatic t_place place_rect(int w, int h);
        t_place r;
        bit found;
        int best, best_top, best_w, bx, by, y, top, i, end_x, shrink;
        r.status = sra_pkg::ST_NOFIT;
        r.place_x = '0;
        r.place_y = '0;
        found = 1'b0;
        best = 0; best_top = 0; best_w = 0; bx = 0; by = 0;
        if (w == 0 || h == 0) return r;
        for (i = 0; i < sky_cnt; i++) begin
            if (span_fits(i, w, h, y)) begin
                top = y + h;
                if (!found || top < best_top || (top == best_top && sky_w[i] < best_w)) begin
                    found = 1'b1;
                    best = i;
                    best_top = top;
                    best_w = sky_w[i];
                    bx = sky_x[i];
                    by = y;
                end
            end
        end
        if (!found) return r;
        if (sky_cnt >= NSEG) begin
            r.status = sra_pkg::ST_FULL;
            return r;
        end
        for (int k = sky_cnt; k > best; k--) begin
            sky_x[k] = sky_x[k-1];
            sky_y[k] = sky_y[k-1];
            sky_w[k] = sky_w[k-1];
        end
        sky_x[best] = bx;
        sky_y[best] = by + h;
        sky_w[best] = w;
        sky_cnt++;
        // trim whatever the new segment covers
        i = best + 1;
        while (i < sky_cnt) begin
            end_x = sky_x[i-1] + sky_w[i-1];
            if (sky_x[i] < end_x) begin
                shrink = end_x - sky_x[i];
                sky_x[i] += shrink;
                sky_w[i] -= shrink;
                if (sky_w[i] <= 0) begin
                    sky_remove(i);
                    continue;
                end
            end
            break;
        end
        i = 0;
        while (i + 1 < sky_cnt) begin
            if (sky_y[i] == sky_y[i+1]) begin
                sky_w[i] += sky_w[i+1];
                sky_remove(i + 1);
            end else begin
                i++;
            end
        end
        r.status = sra_pkg::ST_PLACED;
        r.place_x = bx[sra_pkg::OB-1:0];
        r.place_y = by[sra_pkg::OB-1:0];
        return r;
    endfunction

    task automatic offer(int w, int h, bit typed, t_place want);
        t_place got;
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_width  <= w[sra_pkg::CB-1:0];
        req_ch.req_height <= h[sra_pkg::CB-1:0];
        burst_left--;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        got = place_rect(w & 16'h1FFF, h & 16'h1FFF);
        placements.insert(placements.size(), typed ? want : got);
        n_req++;
    endtask

    task automatic write_reg(logic [sra_pkg::CFG_IB-1:0] idx, int val);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (placements.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val[sra_pkg::CB-1:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == sra_pkg::REG_ATLAS_W) begin
            atl_w = val & 16'h1FFF;
            sky_clear();
        end else if (idx == sra_pkg::REG_ATLAS_H) begin
            atl_h = val & 16'h1FFF;
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_place tp(logic [sra_pkg::SB-1:0] s, int x, int y);
        t_place r;
        r.status = s;
        r.place_x = x[sra_pkg::OB-1:0];
        r.place_y = y[sra_pkg::OB-1:0];
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_place e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_res++;
            if (placements.size() == 0) begin
                $error("unexpected result status=%0d x=%0d y=%0d",
                       res_ch.status, res_ch.place_x, res_ch.place_y);
                n_fail++;
            end else begin
                e = placements.pop_front();
                if (res_ch.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, res_ch.status);
                    n_fail++;
                end
                if (res_ch.place_x !== e.place_x) begin
                    $error("place_x: expected %0d, got %0d", e.place_x, res_ch.place_x);
                    n_fail++;
                end
                if (res_ch.place_y !== e.place_y) begin
                    $error("place_y: expected %0d, got %0d", e.place_y, res_ch.place_y);
                    n_fail++;
                end
                case (e.status)
                    sra_pkg::ST_PLACED: n_placed++;
                    sra_pkg::ST_FULL:   n_full++;
                    default:            n_nofit++;
                endcase
            end
        end
    end

    // result side back-pressure
    initial begin
        int mode, span;
        res_ch.ready = 1'b0;
        mode = 0;
        span = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                res_ch.ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                long_hold = 1'b0;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 200);
            end
            span--;
            case (mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 1) == 1);
                default: res_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog on lack of progress
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("[skyline_rect_allocator] ERROR");
            $finish;
        end
    end

    function automatic int pick_dim(int lim, bit is_w);
        int m;
        m = (lim < 1) ? 1 : lim;
        case ($urandom_range(0, 19))
            0:       return $urandom_range(0, 1) ? 0 : $urandom_range(0, 8191);
            1:       return $urandom_range(0, 8191);
            2:       return m;
            3:       return m + 1;
            default: return is_w ? $urandom_range(1, (m / 3 < 1) ? 1 : m / 3)
                                 : $urandom_range(1, (m / 6 < 1) ? 1 : m / 6);
        endcase
    endfunction

    t_row directed [$];
    int   phase_w [8] = '{1024, 16, 1, 4096, 40, 8191, 300, 4096};
    int   phase_h [8] = '{1024, 4096, 1, 1, 60, 8191, 4096, 4096};

    initial begin
        t_place none;
        none = tp(sra_pkg::ST_NOFIT, 0, 0);
        n_fail = 0; n_req = 0; n_res = 0; n_placed = 0; n_nofit = 0; n_full = 0;
        burst_left = 0;
        idle_cycles = 0;
        long_hold = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_width = '0;
        req_ch.req_height = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        atl_w = sra_pkg::ATLAS_RESET;
        atl_h = sra_pkg::ATLAS_RESET;
        sky_clear();
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed = '{
            '{0, 0, 5, 1, none},
            '{0, 5, 0, 1, none},
            '{0, 1025, 1, 1, none},
            '{0, 1, 1025, 1, none},
            '{0, 8191, 8191, 1, none},
            '{0, 1024, 1024, 1, tp(sra_pkg::ST_PLACED, 0, 0)},
            '{0, 1, 1, 1, none},
            '{1, sra_pkg::REG_ATLAS_H, 4096, 0, none},
            '{0, 100, 10, 0, none},
            '{0, 50, 10, 0, none},
            '{0, 100, 20, 0, none},
            '{0, 874, 10, 0, none},
            '{0, 30, 5, 0, none},
            '{0, 1024, 4000, 0, none},
            '{1, REG_UNUSED, 7, 0, none},
            '{0, 60, 3, 0, none},
            '{1, sra_pkg::REG_ATLAS_W, 0, 0, none},
            '{0, 1, 1, 1, none},
            '{1, sra_pkg::REG_ATLAS_W, 4096, 0, none},
            '{0, 4096, 4096, 1, tp(sra_pkg::ST_PLACED, 0, 0)},
            '{1, sra_pkg::REG_ATLAS_W, 8191, 0, none},
            '{0, 4200, 100, 0, none},
            '{0, 4000, 5000, 0, none}
        };
        foreach (directed[r]) begin
            if (directed[r].is_cfg)
                write_reg(directed[r].a[sra_pkg::CFG_IB-1:0], directed[r].b);
            else
                offer(directed[r].a, directed[r].b, directed[r].typed, directed[r].want);
        end

        // fill the segment store with descending strips, then overflow it
        write_reg(sra_pkg::REG_ATLAS_H, 1024);
        write_reg(sra_pkg::REG_ATLAS_W, 1024);
        for (int k = 0; k < 66; k++) offer(1, 200 - k, 0, none);
        offer(2000, 1, 0, none);

        for (int p = 0; p < 8; p++) begin
            write_reg(sra_pkg::REG_ATLAS_W, phase_w[p]);
            write_reg(sra_pkg::REG_ATLAS_H, phase_h[p]);
            if (p == 1) long_hold = 1'b1;
            for (int k = 0; k < 65; k++)
                offer(pick_dim(phase_w[p], 1), pick_dim(phase_h[p], 0), 0, none);
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (placements.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Covered %0d requests over 10 atlas settings: %0d placed, %0d no fit, %0d full.",
                 n_req, n_placed, n_nofit, n_full);
        $display("Results checked: %0d, mismatches: %0d.", n_res, n_fail);
        if (n_fail == 0) begin
            $display("[skyline_rect_allocator] OK");
        end else begin
            $display("[skyline_rect_allocator] ERROR");
        end
        $finish;
    end
endmodule
